[rtl/core/command_line_tokenizer_assert.svh]
// Assertion macros used by the checker file of the tokenizer.
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define CLT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tokenizer check failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

[rtl/core/clt_pkg.sv]
package clt_pkg;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_WORD  = 3'd1,
		PH_UNQ   = 3'd2,
		PH_STR   = 3'd3,
		PH_ESC   = 3'd4,
		PH_AFTQ  = 3'd5,
		PH_SKIP  = 3'd6,
		PH_DROP  = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_LETTER  = 3'd1,
		ERR_WORDCH  = 3'd2,
		ERR_QUOTE   = 3'd3,
		ERR_NOCLOSE = 3'd4,
		ERR_NOSPACE = 3'd5
	} err_t;

	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_APOS       = 8'h27;
	localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	typedef struct packed {
		logic [7:0] ch;
		logic       want_word;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       token_end;
		logic       line_end;
		logic [2:0] error_code;
	} out_item_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDERSCORE);
	endfunction

	function automatic logic is_unquoted_char(input logic [7:0] c);
		return (c > CH_SPACE) && (c != CH_QUOTE) && (c != CH_APOS);
	endfunction

endpackage

[rtl/core/clt_stream_if.sv]
interface clt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/core/command_line_tokenizer.sv]
// Command line tokenizer.
// The bytes channel carries one byte of a command line per transaction, with
// a zero byte ending the line, and the want_word flag that picks word or
// parameter parsing at each token start. The tokens channel returns exactly
// one result per input byte: the decoded character and its valid flag, the
// token-end and line-end marks, and an error code.
// An accepted byte lands in an input register; the phase machine decodes it
// from there and the result is written to the output register when that
// register is empty or the receiver is ready. One byte is accepted per cycle
// while the receiver is ready.
// When the receiver stalls, the output register holds its result and the
// input register fills, after which bytes.ready drops until tokens.ready
// returns. Reset clears both valid flags and returns the phase machine to
// the start of a line.
module command_line_tokenizer (
	input  logic         clk,
	input  logic         arst_n,
	clt_stream_if.sink   bytes,
	clt_stream_if.source tokens
);

	logic               valid_s1;
	logic               take;
	clt_pkg::in_item_t  item_s1;
	clt_pkg::out_item_t result;

	clt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	clt_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (take),
		.item    (item_s1),
		.result  (result)
	);

	clt_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.pending (valid_s1),
		.result  (result),
		.take    (take),
		.tokens  (tokens)
	);

endmodule

[rtl/core/clt_in_stage.sv]
module clt_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	clt_stream_if.sink        bytes,
	input  logic              take,
	output logic              valid_s1,
	output clt_pkg::in_item_t item_s1
);

	logic accept;

	assign bytes.ready = !valid_s1 || take;
	assign accept      = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= bytes.data;
		end
	end

endmodule

[rtl/core/clt_step.sv]
module clt_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  clt_pkg::in_item_t  item,
	output clt_pkg::out_item_t result
);

	clt_pkg::phase_t phase_q;
	clt_pkg::phase_t ph;
	clt_pkg::phase_t ph_next;
	clt_pkg::err_t   err;
	logic [7:0]      c;
	logic [7:0]      ochar;
	logic            valid;
	logic            tend;
	logic            lend;
	logic            cont_ok;

	assign c = item.ch;

	always_comb begin
		ph      = phase_q;
		ph_next = phase_q;
		err     = clt_pkg::ERR_NONE;
		ochar   = clt_pkg::CH_NUL;
		valid   = 1'b0;
		tend    = 1'b0;
		lend    = 1'b0;
		cont_ok = 1'b0;
		if (phase_q == clt_pkg::PH_SKIP && !clt_pkg::is_space(c)) begin
			ph      = clt_pkg::PH_START;
			ph_next = clt_pkg::PH_START;
		end
		case (ph)
			clt_pkg::PH_SKIP: begin
				ph_next = clt_pkg::PH_SKIP;
			end
			clt_pkg::PH_START: begin
				if (c == clt_pkg::CH_NUL) begin
					lend = 1'b1;
				end else if (item.want_word) begin
					if (clt_pkg::is_alpha(c)) begin
						ochar   = c;
						valid   = 1'b1;
						ph_next = clt_pkg::PH_WORD;
					end else begin
						err = clt_pkg::ERR_LETTER;
					end
				end else if (c == clt_pkg::CH_QUOTE) begin
					ph_next = clt_pkg::PH_STR;
				end else if (clt_pkg::is_unquoted_char(c)) begin
					ochar   = c;
					valid   = 1'b1;
					ph_next = clt_pkg::PH_UNQ;
				end else begin
					err = clt_pkg::ERR_QUOTE;
				end
			end
			clt_pkg::PH_WORD, clt_pkg::PH_UNQ: begin
				cont_ok = (ph == clt_pkg::PH_WORD) ? clt_pkg::is_word_char(c)
				                                   : clt_pkg::is_unquoted_char(c);
				if (c == clt_pkg::CH_NUL) begin
					tend    = 1'b1;
					lend    = 1'b1;
					ph_next = clt_pkg::PH_START;
				end else if (clt_pkg::is_space(c)) begin
					tend    = 1'b1;
					ph_next = clt_pkg::PH_SKIP;
				end else if (cont_ok) begin
					ochar = c;
					valid = 1'b1;
				end else begin
					err = (ph == clt_pkg::PH_WORD) ? clt_pkg::ERR_WORDCH : clt_pkg::ERR_QUOTE;
				end
			end
			clt_pkg::PH_STR: begin
				if (c == clt_pkg::CH_NUL) begin
					err = clt_pkg::ERR_NOCLOSE;
				end else if (c == clt_pkg::CH_QUOTE) begin
					ph_next = clt_pkg::PH_AFTQ;
				end else if (c == clt_pkg::CH_BACKSLASH) begin
					ph_next = clt_pkg::PH_ESC;
				end else begin
					ochar = c;
					valid = 1'b1;
				end
			end
			clt_pkg::PH_ESC: begin
				if (c == clt_pkg::CH_NUL) begin
					err = clt_pkg::ERR_NOCLOSE;
				end else begin
					ochar   = c;
					valid   = 1'b1;
					ph_next = clt_pkg::PH_STR;
				end
			end
			clt_pkg::PH_AFTQ: begin
				if (c == clt_pkg::CH_NUL) begin
					tend    = 1'b1;
					lend    = 1'b1;
					ph_next = clt_pkg::PH_START;
				end else if (clt_pkg::is_space(c)) begin
					tend    = 1'b1;
					ph_next = clt_pkg::PH_SKIP;
				end else begin
					err = clt_pkg::ERR_NOSPACE;
				end
			end
			default: begin
				if (c == clt_pkg::CH_NUL) begin
					lend    = 1'b1;
					ph_next = clt_pkg::PH_START;
				end
			end
		endcase
		if (err != clt_pkg::ERR_NONE) begin
			if (c == clt_pkg::CH_NUL) begin
				lend    = 1'b1;
				ph_next = clt_pkg::PH_START;
			end else begin
				ph_next = clt_pkg::PH_DROP;
			end
		end
		result.out_char   = ochar;
		result.char_valid = valid;
		result.token_end  = tend;
		result.line_end   = lend;
		result.error_code = 3'(err);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= clt_pkg::PH_START;
		end else if (advance) begin
			phase_q <= ph_next;
		end
	end

endmodule

[rtl/core/clt_out_stage.sv]
module clt_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pending,
	input  clt_pkg::out_item_t result,
	output logic               take,
	clt_stream_if.source       tokens
);

	logic               valid_q;
	clt_pkg::out_item_t data_q;

	assign take         = pending && (!valid_q || tokens.ready);
	assign tokens.valid = valid_q;
	assign tokens.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (tokens.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= result;
		end
	end

endmodule

[rtl/core/clt_checker.sv]
`include "command_line_tokenizer_assert.svh"

module clt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input clt_pkg::out_item_t out_data
);

	logic no_err;

	assign no_err = out_data.error_code == 3'(clt_pkg::ERR_NONE);

	`CLT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`CLT_ASSERT(a_char_clean, !out_valid || out_data.char_valid || out_data.out_char == 8'h00)
	`CLT_ASSERT(a_char_no_err, !out_valid || !out_data.char_valid || no_err)
	`CLT_ASSERT(a_tend_no_err, !out_valid || !out_data.token_end || (no_err && !out_data.char_valid))

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (tokens.valid),
	.out_ready (tokens.ready),
	.out_data  (tokens.data)
);
